[rtl/dcf_pkg.sv]
// Package for the dual checksum command framer: widths, frame constants,
// byte positions within a frame and the structs passed between modules.
// No dependencies.
package dcf_pkg;

    localparam int DEF_MAX_PAYLOAD = 64;

    localparam logic [7:0] SYNC_A    = 8'hF8;
    localparam logic [7:0] SYNC_B    = 8'h7C;
    localparam logic [7:0] SYNC_C    = 8'hFF;
    localparam logic [7:0] SYNC_D    = 8'h55;
    localparam logic [7:0] LEN_EXTRA = 8'd4;

    typedef logic [3:0] t_idx;

    localparam t_idx IDX_SYNC_A  = 4'd0;
    localparam t_idx IDX_SYNC_B  = 4'd1;
    localparam t_idx IDX_LEN_EXT = 4'd2;
    localparam t_idx IDX_SYNC_C  = 4'd3;
    localparam t_idx IDX_SYNC_D  = 4'd4;
    localparam t_idx IDX_LEN     = 4'd5;
    localparam t_idx IDX_PAYLOAD = 4'd6;
    localparam t_idx IDX_INNER   = 4'd7;
    localparam t_idx IDX_OUTER   = 4'd8;

    typedef struct packed {
        logic       bad;
        t_idx       first;
        t_idx       last;
        logic [7:0] data;
        logic [6:0] len;
        logic [7:0] inner_chk;
        logic [7:0] outer_chk;
    } t_desc;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
        logic       bad_length;
    } t_res;

endpackage

[rtl/dcf_if.sv]
// Channel interfaces of the dual checksum command framer.
// Depends on nothing; used by the top level.
interface dcf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       frame_start;
    logic [6:0] payload_len;

    modport source (output valid, output payload_byte, output frame_start,
                    output payload_len, input ready);
    modport sink (input valid, input payload_byte, input frame_start,
                  input payload_len, output ready);
endinterface

interface dcf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic       bad_length;

    modport source (output valid, output out_byte, output run_last,
                    output frame_end, output bad_length, input ready);
    modport sink (input valid, input out_byte, input run_last,
                  input frame_end, input bad_length, output ready);
endinterface

[rtl/dual_checksum_command_framer.sv]
// Dual checksum command framer, top level. Uses dcf_pkg, dcf_if,
// dcf_frame_ctl and dcf_emitter.
// The first result of an item passes through the burst buffer and then the output register.
// Throughput: an item causes 1, 3, 7 or 9 results, or none. The emitter gives one output byte
// per cycle while the output side is ready, and takes the next item as the last result is registered.
// Reset: synchronous, active low; clears the frame state and empties both registers.
module dual_checksum_command_framer
    import dcf_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dcf_in_if.sink    i_in,
    dcf_out_if.source o_out
);

    logic  acc;
    logic  desc_valid;
    t_desc desc;
    logic  free;
    t_res  res;

    assign i_in.ready = free;
    assign acc        = i_in.valid && free;

    dcf_frame_ctl #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_ctl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_acc          (acc),
        .i_payload_byte (i_in.payload_byte),
        .i_frame_start  (i_in.frame_start),
        .i_payload_len  (i_in.payload_len),
        .o_desc_valid   (desc_valid),
        .o_desc         (desc)
    );

    dcf_emitter u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (acc && desc_valid),
        .i_desc      (desc),
        .o_free      (free),
        .i_res_ready (o_out.ready),
        .o_res_valid (o_out.valid),
        .o_res       (res)
    );

    assign o_out.out_byte   = res.out_byte;
    assign o_out.run_last   = res.run_last;
    assign o_out.frame_end  = res.frame_end;
    assign o_out.bad_length = res.bad_length;

endmodule

[rtl/dcf_frame_ctl.sv]
// Frame state and checksum update for each accepted input byte.
// Produces one burst descriptor per item that causes results. Uses dcf_pkg.
module dcf_frame_ctl
    import dcf_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc,
    input  logic [7:0] i_payload_byte,
    input  logic       i_frame_start,
    input  logic [6:0] i_payload_len,
    output logic       o_desc_valid,
    output t_desc      o_desc
);

    logic       r_frame_open;
    logic       r_dropping;
    logic [6:0] r_bytes_left;
    logic [7:0] r_inner_sum;
    logic [7:0] r_outer_sum;

    logic       len_bad;
    logic       in_frame;
    logic [6:0] bl_base;
    logic [6:0] n_bytes_left;
    logic [7:0] len8;
    logic [7:0] inner_base;
    logic [7:0] outer_base;
    logic [7:0] n_inner_sum;
    logic [7:0] n_outer_sum;
    logic [7:0] inner_chk;

    assign len_bad  = (i_payload_len == 7'd0) || (i_payload_len > 7'(MAX_PAYLOAD));
    assign in_frame = r_frame_open && !r_dropping;
    assign len8     = {1'b0, i_payload_len};

    assign bl_base      = i_frame_start ? i_payload_len : r_bytes_left;
    assign n_bytes_left = bl_base - 7'd1;
    assign inner_base   = i_frame_start ? len8 : r_inner_sum;
    assign outer_base   = i_frame_start ? (len8 + LEN_EXTRA + SYNC_C + SYNC_D + len8)
                                        : r_outer_sum;
    assign n_inner_sum  = inner_base + i_payload_byte;
    assign n_outer_sum  = outer_base + i_payload_byte;
    assign inner_chk    = ~n_inner_sum;

    assign o_desc_valid      = i_frame_start || in_frame;
    assign o_desc.bad        = i_frame_start && len_bad;
    assign o_desc.first      = (i_frame_start && !len_bad) ? IDX_SYNC_A : IDX_PAYLOAD;
    assign o_desc.last       = (o_desc.bad || n_bytes_left != 7'd0) ? IDX_PAYLOAD
                                                                   : IDX_OUTER;
    assign o_desc.data       = i_payload_byte;
    assign o_desc.len        = i_payload_len;
    assign o_desc.inner_chk  = inner_chk;
    assign o_desc.outer_chk  = n_outer_sum + inner_chk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_dropping   <= 1'b0;
            r_bytes_left <= 7'd0;
            r_inner_sum  <= 8'd0;
            r_outer_sum  <= 8'd0;
        end else if (i_acc) begin
            if (i_frame_start && len_bad) begin
                r_frame_open <= 1'b0;
                r_dropping   <= 1'b1;
                r_bytes_left <= 7'd0;
            end else if (i_frame_start || in_frame) begin
                r_frame_open <= (n_bytes_left != 7'd0);
                r_dropping   <= r_dropping && !i_frame_start;
                r_bytes_left <= n_bytes_left;
                r_inner_sum  <= n_inner_sum;
                r_outer_sum  <= n_outer_sum;
            end
        end
    end

endmodule

[rtl/dcf_emitter.sv]
// Burst buffer and output register: walks one descriptor through its frame
// positions, one result byte per transfer. Uses dcf_pkg.
module dcf_emitter
    import dcf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_desc i_desc,
    output logic  o_free,
    input  logic  i_res_ready,
    output logic  o_res_valid,
    output t_res  o_res
);

    logic  r_dv;
    t_desc r_desc;
    t_idx  r_idx;
    logic  r_ov;
    t_res  r_out;

    logic       adv;
    logic       consume;
    t_res       n_out;
    logic [7:0] sel_byte;

    assign adv     = r_dv && (!r_ov || i_res_ready);
    assign consume = adv && (r_idx == r_desc.last);
    assign o_free  = !r_dv || consume;

    always_comb begin
        case (r_idx)
            IDX_SYNC_A:  sel_byte = SYNC_A;
            IDX_SYNC_B:  sel_byte = SYNC_B;
            IDX_LEN_EXT: sel_byte = {1'b0, r_desc.len} + LEN_EXTRA;
            IDX_SYNC_C:  sel_byte = SYNC_C;
            IDX_SYNC_D:  sel_byte = SYNC_D;
            IDX_LEN:     sel_byte = {1'b0, r_desc.len};
            IDX_PAYLOAD: sel_byte = r_desc.data;
            IDX_INNER:   sel_byte = r_desc.inner_chk;
            IDX_OUTER:   sel_byte = r_desc.outer_chk;
            default:     sel_byte = 8'd0;
        endcase
        n_out.out_byte   = r_desc.bad ? 8'd0 : sel_byte;
        n_out.run_last   = (r_idx == r_desc.last);
        n_out.frame_end  = (r_idx == IDX_OUTER) && !r_desc.bad;
        n_out.bad_length = r_desc.bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_load) begin
                r_dv <= 1'b1;
            end else if (consume) begin
                r_dv <= 1'b0;
            end
            if (adv) begin
                r_ov <= 1'b1;
            end else if (i_res_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_desc <= i_desc;
            r_idx  <= i_desc.first;
        end else if (adv) begin
            r_idx  <= r_idx + t_idx'(1);
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_res_valid = r_ov;
    assign o_res       = r_out;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("Descriptor loaded while a burst is still in progress.");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_idx <= r_desc.last))
        else $error("Burst position ran past its last byte.");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.frame_end) |-> (r_out.run_last && !r_out.bad_length))
        else $error("Frame end byte is not the last result of its item.");

    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.bad_length) |-> (r_out.run_last && r_out.out_byte == 8'd0))
        else $error("Length error result is malformed.");

endmodule
